### sv/critically_damped_smoother_unit_macros.svh
// Assertion macros for the critically damped smoother checker.
// Standalone header, no dependencies.
`ifndef CRITICALLY_DAMPED_SMOOTHER_UNIT_MACROS_SVH
`define CRITICALLY_DAMPED_SMOOTHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CDS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("critically_damped_smoother_unit: check failed");

// Next-cycle implication, disabled during reset.
`define CDS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("critically_damped_smoother_unit: check failed");

`endif

### sv/cds_pkg.sv
// Shared widths, constants and types for the critically damped smoother.
// No dependencies; used by the arithmetic unit, the top level and the checker.
package cds_pkg;

   // port payload widths
   localparam int ST_W  = 24;
   localparam int REQ_W = 48;
   localparam int RSP_W = 64;

   // shared multiply/divide unit
   localparam int MAG_W     = 62;              // multiplicand / dividend magnitude
   localparam int MB_W      = 32;              // multiplier / divisor
   localparam int DIG_W     = 16;              // multiplier digit per cycle
   localparam int PROD_W    = MAG_W + MB_W;
   localparam int MUL_STEPS = MB_W / DIG_W;
   localparam int DIV_W     = 34;              // dividend bits walked by the divider
   localparam int DIV_STEPS = DIV_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_cmd_type;

endpackage

### sv/cds_arith.sv
// Shared iterative arithmetic unit: digit-serial multiplier and restoring divider.
// Depends on cds_pkg.
module cds_arith (
   input  logic                         clock,
   input  logic                         reset,
   input  cds_pkg::arith_cmd_type       cmd,
   input  logic [cds_pkg::MAG_W-1:0]    opa,     // multiplicand or dividend
   input  logic [cds_pkg::MB_W-1:0]     opb,     // multiplier or divisor
   output logic                         done,
   output logic [cds_pkg::PROD_W-1:0]   result   // product or quotient
);
   import cds_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   arith_op_type            op_ff, op_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [MAG_W-1:0]        a_ff, a_in;
   logic [MB_W-1:0]         b_ff, b_in;
   logic [MB_W-1:0]         rem_ff, rem_in;
   logic [PROD_W-1:0]       acc_ff, acc_in;
   logic [MAG_W+DIG_W-1:0]  pp;
   logic [MB_W:0]           trial;
   logic [MB_W:0]           diff;

   // high digit first; the accumulator shifts up one digit per step
   assign pp    = a_ff * b_ff[MB_W-1 -: DIG_W];
   assign trial = {rem_ff, a_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, b_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      if (cmd.start) begin
         op_in   = cmd.op;
         a_in    = opa;
         b_in    = opb;
         rem_in  = '0;
         acc_in  = '0;
         busy_in = 1'b1;
         cnt_in  = (cmd.op == OP_DIV) ? CNT_W'(DIV_STEPS - 1) : CNT_W'(MUL_STEPS - 1);
      end else if (busy_ff) begin
         case (op_ff)
            OP_MUL: begin
               acc_in = (acc_ff << DIG_W) + PROD_W'(pp);
               b_in   = b_ff << DIG_W;
            end
            OP_DIV: begin
               a_in = a_ff << 1;
               if (!diff[MB_W]) begin
                  rem_in = diff[MB_W-1:0];
                  acc_in = {acc_ff[PROD_W-2:0], 1'b1};
               end else begin
                  rem_in = trial[MB_W-1:0];
                  acc_in = {acc_ff[PROD_W-2:0], 1'b0};
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

### sv/critically_damped_smoother_unit.sv
// Critically damped smoother, Q16.16: sequencer, state and one shared mul/div unit.
// Depends on cds_pkg and cds_arith.
//
//   channel | direction | payload (low bits first)
//   req_    | in        | target[31:0], delta_time[47:32]
//   rsp_    | out       | position[31:0], speed[63:32]
//   csr_    | in        | smooth_time[23:0]
//
// An item runs two 34-step divides (omega, decay) and nine multiplies, then the output
// step; the decay divide is skipped when the decay factor is zero.
// req_tready is high only while the sequencer is idle, so a new request waits until the previous item has left.
// Reset clears position and velocity to zero and smooth_time to 6554 (about 0.1 s).
// A result waiting on rsp_ does not block the next request; the sequencer holds
// its final step until the output register is free.
module critically_damped_smoother_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [cds_pkg::REQ_W-1:0]   req_tdata,   // [31:0] target, [47:32] delta_time
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [cds_pkg::RSP_W-1:0]   rsp_tdata,   // [31:0] position, [63:32] speed
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [cds_pkg::ST_W-1:0]    csr_data     // smooth_time
);
   import cds_pkg::*;

   localparam int DATA_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int DT_W    = 16;
   localparam int SW      = 63;
   localparam int OMEGA_W = 31;
   localparam int X_W     = 27;
   localparam int DEN_W   = 33;
   localparam int E_W     = 17;
   localparam int P_LIM   = 64;               // products at or above 2^64 saturate
   localparam int PH_W    = P_LIM - FRAC_W;

   typedef logic signed [SW-1:0] wide_type;

   localparam logic [ST_W-1:0]   ST_RESET = 24'd6554;
   localparam logic [ST_W-1:0]   FLOOR_ST = 24'd7;
   localparam logic [DEN_W-1:0]  K048     = 33'd31457;
   localparam logic [DEN_W-1:0]  K0235    = 33'd15401;
   localparam logic [DEN_W-1:0]  ONE_Q    = 33'h0_0001_0000;
   localparam logic [DEN_W-1:0]  CAP_Q    = 33'h1_0000_0000;
   localparam logic [X_W-1:0]    XCAP     = 27'h400_0000;
   localparam logic [DIV_W-1:0]  DVD_OMEGA = 34'h2_0000_0000;
   localparam logic [DIV_W-1:0]  DVD_DECAY = 34'h1_0000_0000;
   localparam logic [MAG_W-1:0]  ISAT_MAG = {1'b1, 61'd0};
   localparam wide_type          ISAT     = wide_type'({1'b0, 1'b1, 61'd0});
   localparam wide_type          DMAX     = wide_type'(32'sh7FFF_FFFF);
   localparam wide_type          DMIN     = wide_type'(32'sh8000_0000);

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0_0000_0000_0001,
      S_OMEGA = 13'b0_0000_0000_0010,
      S_X     = 13'b0_0000_0000_0100,
      S_DEN1  = 13'b0_0000_0000_1000,
      S_DEN2  = 13'b0_0000_0001_0000,
      S_DEN3  = 13'b0_0000_0010_0000,
      S_E     = 13'b0_0000_0100_0000,
      S_T1    = 13'b0_0000_1000_0000,
      S_TEMP  = 13'b0_0001_0000_0000,
      S_T2    = 13'b0_0010_0000_0000,
      S_NV    = 13'b0_0100_0000_0000,
      S_T3    = 13'b0_1000_0000_0000,
      S_FIN   = 13'b1_0000_0000_0000
   } state_type;

   function automatic wide_type sat_wide(input wide_type v);
      if (v > ISAT) begin
         return ISAT;
      end else if (v < -ISAT) begin
         return -ISAT;
      end
      return v;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_data(input wide_type v);
      if (v > DMAX) begin
         return DMAX[DATA_W-1:0];
      end else if (v < DMIN) begin
         return DMIN[DATA_W-1:0];
      end
      return v[DATA_W-1:0];
   endfunction

   state_type                  state_ff, state_in;
   logic                       issued_ff, issued_in;
   logic                       neg_ff, neg_in;
   logic [ST_W-1:0]            st_ff, st_in;
   logic signed [DATA_W-1:0]   pos_ff, pos_in;
   logic signed [DATA_W-1:0]   vel_ff, vel_in;
   logic signed [DATA_W-1:0]   tgt_ff, tgt_in;
   logic [DT_W-1:0]            dt_ff, dt_in;
   logic signed [DATA_W:0]     ch_ff, ch_in;
   logic [OMEGA_W-1:0]         omega_ff, omega_in;
   logic [X_W-1:0]             x_ff, x_in;
   logic [DEN_W-1:0]           den_ff, den_in;
   logic [E_W-1:0]             e_ff, e_in;
   wide_type                   temp_ff, temp_in;
   wide_type                   mres_ff, mres_in;
   wide_type                   nvw_ff, nvw_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]           rsp_data_ff, rsp_data_in;

   arith_cmd_type              cmd;
   logic [MAG_W-1:0]           opa;
   logic [MB_W-1:0]            opb;
   logic                       arith_done;
   logic [PROD_W-1:0]          arith_res;

   logic [ST_W-1:0]            st_eff;
   logic signed [DATA_W-1:0]   req_target;
   logic                       uses_unit;
   logic                       signed_op;
   arith_op_type               op_kind;
   logic [MAG_W-1:0]           uopa;
   wide_type                   sop;
   wide_type                   sop_abs;
   logic [PH_W-1:0]            p_hi;
   logic                       p_over;
   wide_type                   sres_abs;
   wide_type                   sres;
   logic [X_W-1:0]             x_new;
   logic [DEN_W-1:0]           den_prod;
   wide_type                   np;
   logic                       overshoot;
   logic signed [DATA_W-1:0]   pos_next;
   logic signed [DATA_W-1:0]   vel_next;

   cds_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opa    (opa),
      .opb    (opb),
      .done   (arith_done),
      .result (arith_res)
   );

   assign st_eff     = (st_ff < FLOOR_ST) ? FLOOR_ST : st_ff;
   assign req_target = req_tdata[DATA_W-1:0];

   // operand selection for the step the sequencer is in
   always_comb begin
      uses_unit = 1'b1;
      signed_op = 1'b0;
      op_kind   = OP_MUL;
      uopa      = '0;
      sop       = '0;
      opb       = '0;
      case (state_ff)
         S_OMEGA: begin
            op_kind = OP_DIV;
            uopa    = MAG_W'(DVD_OMEGA);
            opb     = MB_W'(st_eff);
         end
         S_X: begin
            uopa = MAG_W'(omega_ff);
            opb  = MB_W'(dt_ff);
         end
         S_DEN1: begin
            uopa = MAG_W'(K0235);
            opb  = MB_W'(x_ff);
         end
         S_DEN2, S_DEN3: begin
            uopa = MAG_W'(den_ff);
            opb  = MB_W'(x_ff);
         end
         S_E: begin
            uses_unit = !den_ff[DEN_W-1];
            op_kind   = OP_DIV;
            uopa      = MAG_W'(DVD_DECAY);
            opb       = den_ff[MB_W-1:0];
         end
         S_T1: begin
            signed_op = 1'b1;
            sop       = SW'(ch_ff);
            opb       = MB_W'(omega_ff);
         end
         S_TEMP: begin
            signed_op = 1'b1;
            sop       = sat_wide(SW'(vel_ff) + mres_ff);
            opb       = MB_W'(dt_ff);
         end
         S_T2: begin
            signed_op = 1'b1;
            sop       = temp_ff;
            opb       = MB_W'(omega_ff);
         end
         S_NV: begin
            signed_op = 1'b1;
            sop       = sat_wide(SW'(vel_ff) - mres_ff);
            opb       = MB_W'(e_ff);
         end
         S_T3: begin
            signed_op = 1'b1;
            sop       = sat_wide(SW'(ch_ff) + temp_ff);
            opb       = MB_W'(e_ff);
         end
         default: begin
            uses_unit = 1'b0;
         end
      endcase
   end

   assign sop_abs   = sop[SW-1] ? -sop : sop;
   assign opa       = signed_op ? sop_abs[MAG_W-1:0] : uopa;
   assign cmd.start = uses_unit && !issued_ff;
   assign cmd.op    = op_kind;

   // result post-processing
   assign p_hi     = arith_res[P_LIM-1:FRAC_W];
   assign p_over   = |arith_res[PROD_W-1:P_LIM];
   assign sres_abs = wide_type'({1'b0, (p_over ? ISAT_MAG : MAG_W'(p_hi))});
   assign sres     = neg_ff ? -sres_abs : sres_abs;
   assign x_new    = (p_hi > PH_W'(XCAP)) ? XCAP : p_hi[X_W-1:0];
   assign den_prod = (p_hi > PH_W'(CAP_Q)) ? CAP_Q : p_hi[DEN_W-1:0];

   // final step: overshoot uses the position before it is clamped to 32 bits
   assign np        = sat_wide(SW'(tgt_ff) + mres_ff);
   assign overshoot = (pos_ff < tgt_ff) == (np > SW'(tgt_ff));
   assign pos_next  = overshoot ? tgt_ff : sat_data(np);
   assign vel_next  = overshoot ? '0 : sat_data(nvw_ff);

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      neg_in       = neg_ff;
      st_in        = st_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      tgt_in       = tgt_ff;
      dt_in        = dt_ff;
      ch_in        = ch_ff;
      omega_in     = omega_ff;
      x_in         = x_ff;
      den_in       = den_ff;
      e_in         = e_ff;
      temp_in      = temp_ff;
      mres_in      = mres_ff;
      nvw_in       = nvw_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         st_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.start) begin
         issued_in = 1'b1;
         neg_in    = signed_op && sop[SW-1];
      end
      if (arith_done) begin
         issued_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               tgt_in   = req_target;
               dt_in    = req_tdata[REQ_W-1:DATA_W];
               ch_in    = (DATA_W + 1)'(pos_ff) - (DATA_W + 1)'(req_target);
               state_in = S_OMEGA;
            end
         end
         S_OMEGA: begin
            if (arith_done) begin
               omega_in = arith_res[OMEGA_W-1:0];
               state_in = S_X;
            end
         end
         S_X: begin
            if (arith_done) begin
               x_in     = x_new;
               state_in = S_DEN1;
            end
         end
         S_DEN1: begin
            if (arith_done) begin
               den_in   = den_prod + K048;
               state_in = S_DEN2;
            end
         end
         S_DEN2: begin
            if (arith_done) begin
               den_in   = den_prod + ONE_Q;
               state_in = S_DEN3;
            end
         end
         S_DEN3: begin
            if (arith_done) begin
               den_in   = den_prod + ONE_Q;
               state_in = S_E;
            end
         end
         S_E: begin
            // denominator at or past 2^32 (65536.0 in Q16): decay is taken as zero, skip the divide
            if (den_ff[DEN_W-1]) begin
               e_in     = '0;
               state_in = S_T1;
            end else if (arith_done) begin
               e_in     = arith_res[E_W-1:0];
               state_in = S_T1;
            end
         end
         S_T1: begin
            if (arith_done) begin
               mres_in  = sres;
               state_in = S_TEMP;
            end
         end
         S_TEMP: begin
            if (arith_done) begin
               temp_in  = sres;
               state_in = S_T2;
            end
         end
         S_T2: begin
            if (arith_done) begin
               mres_in  = sres;
               state_in = S_NV;
            end
         end
         S_NV: begin
            if (arith_done) begin
               nvw_in   = sres;
               state_in = S_T3;
            end
         end
         S_T3: begin
            if (arith_done) begin
               mres_in  = sres;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               pos_in       = pos_next;
               vel_in       = vel_next;
               rsp_data_in  = {vel_next, pos_next};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         st_ff        <= ST_RESET;
         pos_ff       <= '0;
         vel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         st_ff        <= st_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      tgt_ff      <= tgt_in;
      dt_ff       <= dt_in;
      ch_ff       <= ch_in;
      omega_ff    <= omega_in;
      x_ff        <= x_in;
      den_ff      <= den_in;
      e_ff        <= e_in;
      temp_ff     <= temp_in;
      mres_ff     <= mres_in;
      nvw_ff      <= nvw_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

### sv/cds_checker.sv
// Port-level checks for the critically damped smoother, bound to the top level.
// Depends on cds_pkg and critically_damped_smoother_unit_macros.svh.
`include "critically_damped_smoother_unit_macros.svh"

module cds_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [cds_pkg::RSP_W-1:0]   rsp_tdata,   // [31:0] position, [63:32] speed
   input  logic                        csr_valid,
   input  logic                        csr_ready
);
   import cds_pkg::*;

   logic req_fire;
   logic rsp_stall;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // a stalled result holds
   `CDS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   // one request at a time: busy right after an accept
   `CDS_ASSERT_NXT(a_busy_after_req, clock, reset, req_fire, !req_tready)
   // a new result only comes out of the final busy step
   `CDS_ASSERT_IMP(a_rsp_from_busy, clock, reset, $rose(rsp_tvalid), !$past(req_tready))
   // register writes are never back-pressured
   `CDS_ASSERT_IMP(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind critically_damped_smoother_unit cds_checker u_cds_checker (.*);

### tb/sv/critically_damped_smoother_unit_checker.sv
// Checker for the critically damped smoother: tracks smooth_time writes, predicts
// position and speed for each accepted request and compares them with the results.
// Depends on cds_pkg for the port widths.
module critically_damped_smoother_unit_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [cds_pkg::REQ_W-1:0]   req_tdata,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [cds_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [cds_pkg::ST_W-1:0]    csr_data,
   output int                          mismatch_count,
   output int                          pending_count
);
   import cds_pkg::*;

   localparam longint unsigned ONE_Q    = 64'd1 << 16;
   localparam longint unsigned CAP_Q    = 64'd1 << 32;
   localparam longint unsigned XCAP_Q   = 64'd1024 << 16;
   localparam longint unsigned K048     = ((64'd48 << 16) + 64'd50) / 64'd100;
   localparam longint unsigned K0235    = ((64'd235 << 16) + 64'd500) / 64'd1000;
   localparam logic [ST_W-1:0] ST_FLOOR = 24'd7;
   localparam logic [ST_W-1:0] ST_RESET = 24'd6554;
   localparam longint          LIM61    = longint'(1) << 61;
   localparam longint          WORD_MAX = 64'sd2147483647;
   localparam longint          WORD_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] speed;
      logic signed [31:0] position;
   } smoothed_sample_type;

   logic [ST_W-1:0]     smooth_time;
   longint              cur_position;
   longint              cur_velocity;
   smoothed_sample_type predicted_motion[$];

   function automatic longint clamp61(input longint v);
      if (v > LIM61) return LIM61;
      if (v < -LIM61) return -LIM61;
      return v;
   endfunction

   function automatic longint clamp_word(input longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   // unsigned Q16 product for the decay polynomial, floored, capped at 2^32
   function automatic longint unsigned poly_mul(input longint unsigned a,
                                               input longint unsigned b);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> 16;
      return (p > CAP_Q) ? CAP_Q : p[63:0];
   endfunction

   // signed times unsigned, magnitude shifted (toward zero), saturated at 2^61
   function automatic longint gain_mul(input longint a, input longint unsigned b,
                                       input int sh);
      longint          sa;
      logic            neg;
      longint unsigned mag;
      longint unsigned r;
      logic [127:0]    p;
      sa  = clamp61(a);
      neg = (sa < 0);
      mag = neg ? -sa : sa;
      p   = {64'd0, mag} * {64'd0, b};
      if (p[127:64] != 64'd0) begin
         r = LIM61;
      end else begin
         r = p[63:0] >> sh;
         if (r > LIM61) r = LIM61;
      end
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic smoothed_sample_type advance_spring(input logic signed [31:0] target,
                                                         input logic [15:0] dt);
      smoothed_sample_type out;
      longint unsigned     st, omega, x, den, decay, dtq;
      longint              tgt, gap, lead, nv, np;
      st    = (smooth_time < ST_FLOOR) ? ST_FLOOR : smooth_time;
      dtq   = dt;
      omega = (64'd1 << 33) / st;
      x     = (omega * dtq) >> 16;
      if (x > XCAP_Q) x = XCAP_Q;
      den   = poly_mul(K0235, x) + K048;
      den   = poly_mul(den, x) + ONE_Q;
      den   = poly_mul(den, x) + ONE_Q;
      decay = (den >= CAP_Q) ? 64'd0 : CAP_Q / den;

      tgt  = longint'(target);
      gap  = clamp61(cur_position - tgt);
      lead = gain_mul(clamp61(cur_velocity + gain_mul(gap, omega, 16)), dtq, 16);
      nv   = gain_mul(clamp61(cur_velocity - gain_mul(lead, omega, 16)), decay, 16);
      np   = clamp61(tgt + gain_mul(clamp61(gap + lead), decay, 16));

      // overshoot seen from the starting side: land on the target and stop
      if (((tgt - cur_position) > 0) == (np > tgt)) begin
         np = tgt;
         nv = 0;
      end

      cur_position = clamp_word(np);
      cur_velocity = clamp_word(nv);
      out.position = cur_position[31:0];
      out.speed    = cur_velocity[31:0];
      return out;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s got %h expected %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      smoothed_sample_type due;
      smoothed_sample_type seen;
      if (reset) begin
         smooth_time    = ST_RESET;
         cur_position   = 0;
         cur_velocity   = 0;
         mismatch_count = 0;
         predicted_motion.delete();
      end else begin
         if (csr_valid && csr_ready) smooth_time = csr_data;
         if (req_tvalid && req_tready)
            predicted_motion.push_back(advance_spring(req_tdata[31:0], req_tdata[47:32]));
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (predicted_motion.size() == 0) begin
               report_mismatch("result with no request", seen.position, 32'h0);
            end else begin
               due = predicted_motion.pop_front();
               if (seen.position !== due.position)
                  report_mismatch("position", seen.position, due.position);
               if (seen.speed !== due.speed)
                  report_mismatch("speed", seen.speed, due.speed);
            end
         end
      end
      pending_count <= predicted_motion.size();
   end

endmodule

### tb/sv/critically_damped_smoother_unit_tb.sv
// Testbench top for the critically damped smoother: clock, reset, request and
// smooth_time stimulus, result-side stalls and the final verdict.
// Depends on cds_pkg, critically_damped_smoother_unit and its checker.
module critically_damped_smoother_unit_tb;
   import cds_pkg::*;

   localparam int  HOLD_CYCLES  = 1500;
   localparam int  PHASE_ITEMS  = 135;
   localparam real RUN_LIMIT    = 48_000_000.0;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata;     // [31:0] target, [47:32] delta_time
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;     // [31:0] position, [63:32] speed
   logic               csr_valid;
   logic               csr_ready;
   logic [ST_W-1:0]    csr_data;      // smooth_time

   int                 mismatch_count;
   int                 pending_count;
   int                 sender_idle_pct;
   int                 receiver_stall_pct;
   int                 hold_asked;
   int                 hold_served;
   logic signed [31:0] run_target;
   int                 run_left;

   critically_damped_smoother_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   critically_damped_smoother_unit_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side: random stalls, occasional long ones, and one long hold-off on demand
   initial begin
      rsp_tready  = 1'b0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served++;
         end else if ($urandom_range(99) < receiver_stall_pct) begin
            rsp_tready <= 1'b0;
            if ($urandom_range(9) == 0) repeat ($urandom_range(1, 200)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic signed [31:0] target, input logic [15:0] dt);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {dt, target};
      do @(posedge clock); while (!req_tready);
      gap = 0;
      if ($urandom_range(99) < sender_idle_pct)
         gap = ($urandom_range(3) == 0) ? $urandom_range(1, 160) : $urandom_range(1, 4);
      // valid stays up when the next request follows at once
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_smooth_time(input logic [ST_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly frame-rate steps toward a target held for a run, plus noise and extremes
   task automatic random_item();
      int                 pick;
      logic signed [31:0] target;
      logic [15:0]        dt;
      if (run_left == 0) begin
         if ($urandom_range(3) == 0) run_target = $urandom;
         else run_target = int'($urandom_range(0, 131072000)) - 65536000;
         run_left = $urandom_range(1, 24);
      end
      run_left--;
      pick = $urandom_range(99);
      if (pick < 65) begin
         target = run_target;
         dt     = 16'($urandom_range(0, 3000));
      end else if (pick < 80) begin
         target = run_target + int'($urandom_range(0, 1023)) - 512;
         dt     = 16'($urandom);
      end else if (pick < 95) begin
         target = $urandom;
         dt     = 16'($urandom);
      end else begin
         case ($urandom_range(3))
            0: target = 32'sh7FFF_FFFF;
            1: target = 32'sh8000_0000;
            2: target = 32'sh0;
            default: target = run_target;
         endcase
         dt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
      send_request(target, dt);
   endtask

   initial begin
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      csr_valid          = 1'b0;
      csr_data           = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_asked         = 0;
      run_target         = 0;
      run_left           = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset smooth_time
      send_request(32'sh0, 16'd0);                  // at target, no time step
      send_request(32'sh0001_0000, 16'd0);          // no time step, position held
      repeat (4) send_request(32'sh0001_0000, 16'd1092);
      send_request(32'sh7FFF_FFFF, 16'hFFFF);
      send_request(32'sh8000_0000, 16'hFFFF);
      send_request(32'sh8000_0000, 16'd1);
      repeat (3) send_request(-32'sh0005_0000, 16'd1092);
      send_request(32'sh7FFF_FFFF, 16'h8000);
      send_request(32'sh0, 16'hFFFF);
      send_request(32'sh5555_5555, 16'hAAAA);
      send_request(32'shAAAA_AAAA, 16'h5555);
      drain();
      write_smooth_time(24'd0);                     // below the floor
      send_request(32'sh0003_0000, 16'd1);
      send_request(-32'sh0003_0000, 16'hFFFF);
      drain();
      write_smooth_time(24'hFF_FFFF);
      send_request(32'sh0064_0000, 16'hFFFF);
      send_request(32'sh0064_0000, 16'd0);

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
            default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
         endcase
         case (phase)
            0: write_smooth_time(ST_W'($urandom_range(7, 70000)));
            1: write_smooth_time(24'd7);
            2: write_smooth_time(24'd3277);
            3: write_smooth_time(24'hFF_FFFF);
            4: write_smooth_time(ST_W'($urandom_range(0, 24'hFF_FFFF)));
            5: write_smooth_time(24'd6554);
            6: write_smooth_time(ST_W'($urandom_range(1000, 200000)));
            default: write_smooth_time(24'd0);
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 2 && i == 40) hold_asked++;     // sender keeps offering
            if (phase == 5 && i == 60) drain();          // pause until all results are in
            random_item();
         end
      end

      drain();
      repeat (150) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### critically_damped_smoother_unit.f
+incdir+sv
sv/cds_pkg.sv
sv/cds_arith.sv
sv/critically_damped_smoother_unit.sv
sv/cds_checker.sv
tb/sv/critically_damped_smoother_unit_checker.sv
tb/sv/critically_damped_smoother_unit_tb.sv
